// File: design/vmc_pkg.sv
// Package for the vertical median cleaner: word types, pipeline structs,
// register indexes, reset values and result kinds.
// No dependencies; every other design file but vmc_ram refers to it by scoped names.
`default_nettype none

package vmc_pkg;

  // Widths fixed by the word formats.
  localparam int PIX_W  = 16;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;
  localparam int NSLOTS = 4;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SAMPLE_BITS  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [1:0]  RST_FILTER_MODE  = 2'd1;
  localparam logic [12:0] RST_FRAME_WIDTH  = 13'd1920;
  localparam logic [15:0] RST_FRAME_HEIGHT = 16'd1080;
  localparam logic [4:0]  RST_SAMPLE_BITS  = 5'd8;

  // Filter mode codes.
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;
  localparam logic [1:0] MODE_RELAX  = 2'd2;

  // Input word action codes.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // How the result of a word is formed.
  localparam logic [1:0] KIND_PASS   = 2'd0; // incoming pixel as it is
  localparam logic [1:0] KIND_CENTRE = 2'd1; // stored centre row (borders, drain)
  localparam logic [1:0] KIND_MED    = 2'd2; // three-row median
  localparam logic [1:0] KIND_RELAX  = 2'd3; // relaxed five-row median

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_done;
  } out_word_t;

  // What travels with a word from the line store read to the result.
  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       base;  // line store slot of the centre row
    logic [PIX_W-1:0] pix;
    logic             done;
  } stage_t;

  // Decision taken for a word as it is accepted.
  typedef struct packed {
    logic       res_valid;
    logic       wr_en;
    logic [1:0] wr_slot;
    stage_t     stage;
  } item_t;

endpackage

`default_nettype wire

// File: design/vertical_median_cleaner_top.sv
// Top level of the vertical median cleaner: four line store RAMs, the frame
// sequencer, the read stage and the output register.
// Depends on vmc_pkg, vmc_ram, vmc_ctrl and vmc_filter.
//
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall   | vmc_pkg::in_word_t (action, pixel_in)
//  out_    | output    | out_valid/out_stall | vmc_pkg::out_word_t (pixel_out, frame_done)
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One word is taken per cycle while in_stall is low; its result passes through the read
// stage and then the output register. The four line store RAMs are read at the word's
// column and, for a pixel word, one of them is written in the same cycle, which allows
// one word per clock. Reset clears the counters and loads register defaults; the RAMs
// need no clearing. A stalled output holds the read stage, and in_stall rises only
// while both the read stage and the output register are full.
`default_nettype none

module vertical_median_cleaner_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire vmc_pkg::in_word_t          in_word,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      vmc_pkg::out_word_t         out_word,
  input  wire logic                       cfg_we,
  input  wire logic [vmc_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [vmc_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic                                  accept;
  logic                                  adv;
  vmc_pkg::item_t                        item;
  logic [AW-1:0]                         col;
  logic [vmc_pkg::PIX_W-1:0]             peak;
  logic [3:0][vmc_pkg::PIX_W-1:0]        rows;
  logic [vmc_pkg::PIX_W-1:0]             pix_res;

  logic                                  s1_valid_r, s1_valid_nxt;
  vmc_pkg::stage_t                       s1_stage_r;
  logic                                  out_valid_r, out_valid_nxt;
  vmc_pkg::out_word_t                    out_word_r;

  // Handshake: the read stage moves on when the output register frees up.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  vmc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_word   (in_word),
    .item      (item),
    .col       (col),
    .peak      (peak)
  );

  // One line store RAM per row slot, all read at the word's column.
  for (genvar i = 0; i < vmc_pkg::NSLOTS; i++) begin : g_slot
    vmc_ram #(
      .WIDTH (vmc_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk   (clk),
      .we    (accept && item.wr_en && (item.wr_slot == 2'(i))),
      .waddr (col),
      .wdata (in_word.pixel_in),
      .re    (accept),
      .raddr (col),
      .rdata (rows[i])
    );
  end

  vmc_filter u_filter (
    .stage   (s1_stage_r),
    .rows    (rows),
    .peak    (peak),
    .pix_out (pix_res)
  );

  // Read stage and output register control.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = item.res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_stage_r <= item.stage;
    end
    if (adv && s1_valid_r) begin
      out_word_r.pixel_out  <= pix_res;
      out_word_r.frame_done <= s1_stage_r.done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A word that yields a result reaches the read stage.
  a_res_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.res_valid |=> s1_valid_r)
    else $error("result word lost before the read stage");

  // A full read stage moves into the output register when it is free.
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && adv |=> out_valid_r)
    else $error("read stage did not reach the output register");

  // Input is held back only while the output side is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall && s1_valid_r)
    else $error("input stalled without a blocked output");

  // Reset empties both pipeline stages.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: design/vmc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write of the same address in one cycle return the old data.
// Depends on nothing.
`default_nettype none

module vmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-before-write storage array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: design/vmc_ctrl.sv
// Frame sequencer: configuration registers, column, row and drain counters,
// and the per-word decision of which line store rows feed the result.
// Depends on vmc_pkg.
`default_nettype none

module vmc_ctrl #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [vmc_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [vmc_pkg::CFG_DW-1:0]   cfg_wdata,
  input  wire logic                         accept,
  input  wire vmc_pkg::in_word_t            in_word,
  output      vmc_pkg::item_t               item,
  output      logic [$clog2(MAX_WIDTH)-1:0] col,
  output      logic [vmc_pkg::PIX_W-1:0]    peak
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [1:0]    filter_mode_r;
  logic [12:0]   frame_width_r;
  logic [15:0]   frame_height_r;
  logic [4:0]    sample_bits_r;
  logic [AW-1:0] col_r, col_nxt;
  logic [15:0]   row_r, row_nxt;
  logic [1:0]    drain_r, drain_nxt;

  logic [13:0]   w_eff;
  logic [15:0]   h_eff;
  logic [1:0]    delay;
  logic [4:0]    bits_sat;
  logic [16:0]   peak_wide;
  logic [13:0]   col_inc;
  logic          col_wrap;
  logic [15:0]   row_inc;
  logic [1:0]    drain_inc;
  logic [1:0]    row_slot;

  // Effective frame geometry and row delay.
  always_comb begin
    if (frame_width_r == 13'd0) begin
      w_eff = 14'd1;
    end else if ({1'b0, frame_width_r} > 14'(MAX_WIDTH)) begin
      w_eff = 14'(MAX_WIDTH);
    end else begin
      w_eff = {1'b0, frame_width_r};
    end
    h_eff = (frame_height_r == 16'd0) ? 16'd1 : frame_height_r;
    if (filter_mode_r == vmc_pkg::MODE_MEDIAN && h_eff >= 16'd3) begin
      delay = 2'd1;
    end else if (filter_mode_r == vmc_pkg::MODE_RELAX && h_eff >= 16'd5) begin
      delay = 2'd2;
    end else begin
      delay = 2'd0;
    end
  end

  // Saturation peak for the relaxed median.
  always_comb begin
    if (sample_bits_r < 5'd8) begin
      bits_sat = 5'd8;
    end else if (sample_bits_r > 5'd16) begin
      bits_sat = 5'd16;
    end else begin
      bits_sat = sample_bits_r;
    end
    peak_wide = (17'd1 << bits_sat) - 17'd1;
  end

  assign peak = peak_wide[15:0];
  assign col  = col_r;

  assign col_inc   = 14'(col_r) + 14'd1;
  assign col_wrap  = (col_inc >= w_eff);
  assign row_inc   = row_r + 16'd1;
  assign drain_inc = drain_r + 2'd1;
  assign row_slot  = row_r[1:0];

  // Per-word decision and counter update.
  always_comb begin
    item           = '0;
    item.stage.pix = in_word.pixel_in;
    col_nxt        = col_r;
    row_nxt        = row_r;
    drain_nxt      = drain_r;
    if (cfg_we) begin
      col_nxt   = '0;
      row_nxt   = '0;
      drain_nxt = '0;
    end else if (accept) begin
      if (in_word.action == vmc_pkg::ACT_DRAIN) begin
        // Flush one pending pixel of the last rows.
        if (delay != 2'd0 && row_r >= h_eff) begin
          item.res_valid  = 1'b1;
          item.stage.kind = vmc_pkg::KIND_CENTRE;
          item.stage.base = h_eff[1:0] - delay + drain_r;
          col_nxt         = col_inc[AW-1:0];
          if (col_wrap) begin
            col_nxt   = '0;
            drain_nxt = drain_inc;
            if (drain_inc >= delay) begin
              item.stage.done = 1'b1;
              row_nxt         = '0;
              drain_nxt       = '0;
            end
          end
        end
      end else if (row_r < h_eff) begin
        // New pixel: store it and decide the result it releases.
        item.wr_en   = 1'b1;
        item.wr_slot = row_slot;
        case (delay)
          2'd0: begin
            item.res_valid  = 1'b1;
            item.stage.kind = vmc_pkg::KIND_PASS;
          end
          2'd1: begin
            if (row_r >= 16'd1) begin
              item.res_valid  = 1'b1;
              item.stage.base = row_slot - 2'd1;
              item.stage.kind = (row_r == 16'd1) ? vmc_pkg::KIND_CENTRE
                                                 : vmc_pkg::KIND_MED;
            end
          end
          2'd2: begin
            if (row_r >= 16'd2) begin
              item.res_valid  = 1'b1;
              item.stage.base = row_slot - 2'd2;
              item.stage.kind = (row_r < 16'd4) ? vmc_pkg::KIND_CENTRE
                                                : vmc_pkg::KIND_RELAX;
            end
          end
          default: begin
            item.res_valid = 1'b0;
          end
        endcase
        col_nxt = col_inc[AW-1:0];
        if (col_wrap) begin
          col_nxt = '0;
          row_nxt = row_inc;
          if (row_inc >= h_eff && delay == 2'd0) begin
            item.stage.done = 1'b1;
            row_nxt         = '0;
            drain_nxt       = '0;
          end
        end
      end
    end
  end

  // Configuration registers and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r  <= vmc_pkg::RST_FILTER_MODE;
      frame_width_r  <= vmc_pkg::RST_FRAME_WIDTH;
      frame_height_r <= vmc_pkg::RST_FRAME_HEIGHT;
      sample_bits_r  <= vmc_pkg::RST_SAMPLE_BITS;
      col_r          <= '0;
      row_r          <= '0;
      drain_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vmc_pkg::REG_FILTER_MODE:  filter_mode_r  <= cfg_wdata[1:0];
          vmc_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[12:0];
          vmc_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[15:0];
          vmc_pkg::REG_SAMPLE_BITS:  sample_bits_r  <= cfg_wdata[4:0];
          default:                   filter_mode_r  <= filter_mode_r;
        endcase
      end
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/vmc_filter.sv
// Result datapath: picks the column samples out of the four line store
// slots and forms the pass, centre, three-row median or relaxed median.
// Depends on vmc_pkg.
`default_nettype none

module vmc_filter (
  input  wire vmc_pkg::stage_t                   stage,
  input  wire logic [3:0][vmc_pkg::PIX_W-1:0]    rows,
  input  wire logic [vmc_pkg::PIX_W-1:0]         peak,
  output      logic [vmc_pkg::PIX_W-1:0]         pix_out
);

  typedef logic signed [17:0] sval_t;

  logic [vmc_pkg::PIX_W-1:0] c, prv1, prv2, nxt1, dn;
  logic [vmc_pkg::PIX_W-1:0] med_lo, med_hi, med;
  sval_t pk, p2, p1, cs, n1, n2;
  sval_t up_a, up_b, up_v, lo_a, lo_b, lo_v, rel;

  function automatic sval_t lim(input sval_t v, input sval_t lo, input sval_t hi);
    sval_t r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  function automatic sval_t smin(input sval_t a, input sval_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic sval_t smax(input sval_t a, input sval_t b);
    return (a > b) ? a : b;
  endfunction

  // Rows around the centre slot of this column.
  assign c    = rows[stage.base];
  assign prv1 = rows[2'(stage.base - 2'd1)];
  assign prv2 = rows[2'(stage.base - 2'd2)];
  assign nxt1 = rows[2'(stage.base + 2'd1)];
  assign dn   = stage.pix;

  // Three-row median: clamp the centre between the outer pair.
  always_comb begin
    med_lo = (prv1 < dn) ? prv1 : dn;
    med_hi = (prv1 > dn) ? prv1 : dn;
    med    = (c > med_lo) ? c : med_lo;
    med    = (med < med_hi) ? med : med_hi;
  end

  // Relaxed median with ramp extrapolation saturated to zero and the peak.
  always_comb begin
    pk   = sval_t'({2'b00, peak});
    p2   = sval_t'({2'b00, prv2});
    p1   = sval_t'({2'b00, prv1});
    cs   = sval_t'({2'b00, c});
    n1   = sval_t'({2'b00, nxt1});
    n2   = sval_t'({2'b00, dn});
    up_a = lim(lim(p1 - p2, 18'sd0, pk) + p1, 18'sd0, pk);
    up_b = lim(lim(n1 - n2, 18'sd0, pk) + n1, 18'sd0, pk);
    up_v = smax(smax(smin(up_a, up_b), p1), n1);
    lo_a = lim(p1 - lim(p2 - p1, 18'sd0, pk), 18'sd0, pk);
    lo_b = lim(n1 - lim(n2 - n1, 18'sd0, pk), 18'sd0, pk);
    lo_v = smin(smin(p1, n1), smax(lo_a, lo_b));
    rel  = lim(cs, lo_v, up_v);
  end

  // Result selection.
  always_comb begin
    case (stage.kind)
      vmc_pkg::KIND_PASS:   pix_out = dn;
      vmc_pkg::KIND_CENTRE: pix_out = c;
      vmc_pkg::KIND_MED:    pix_out = med;
      vmc_pkg::KIND_RELAX:  pix_out = rel[15:0];
      default:              pix_out = dn;
    endcase
  end

endmodule

`default_nettype wire
